/* hdl/hrlc_pkg.sv */
package hrlc_pkg;

  localparam int unsigned MaxLine = 1024;
  localparam logic [9:0] PosMax = (MaxLine - 1 < 1023) ? 10'(MaxLine - 1) : 10'd1023;
  localparam logic [9:0] CntMax = 10'd1023;
  localparam logic [3:0] CharSat = 4'd9;
  localparam logic [7:0] Space = 8'h20;

  typedef enum logic [1:0] {
    MethNone = 2'd0,
    MethGet  = 2'd1,
    MethPost = 2'd2,
    MethHead = 2'd3
  } method_e;

  typedef struct packed {
    logic [9:0] pos;
    logic [1:0] tc;
    logic       in_tok;
    logic [3:0] cit;
    logic [3:0] alive;
    method_e    meth;
    logic [9:0] poff;
    logic [9:0] pcnt;
    logic       vok;
    logic       extra;
  } st_t;

  typedef struct packed {
    method_e    method;
    logic       bad_request;
    logic       bad_version;
    logic       short_path;
    logic       no_tokens;
    logic [9:0] path_start;
    logic [9:0] path_length;
  } res_t;

  localparam st_t StReset = '{
    pos: 10'd0, tc: 2'd0, in_tok: 1'b0, cit: 4'd0, alive: 4'hF, meth: MethNone,
    poff: 10'd0, pcnt: 10'd0, vok: 1'b0, extra: 1'b0
  };

  function automatic logic get_hit(logic [3:0] i, logic [7:0] c);
    logic h;
    case (i)
      4'd0: h = (c == "G");
      4'd1: h = (c == "E");
      4'd2: h = (c == "T");
      default: h = 1'b0;
    endcase
    return h;
  endfunction

  function automatic logic post_hit(logic [3:0] i, logic [7:0] c);
    logic h;
    case (i)
      4'd0: h = (c == "P");
      4'd1: h = (c == "O");
      4'd2: h = (c == "S");
      4'd3: h = (c == "T");
      default: h = 1'b0;
    endcase
    return h;
  endfunction

  function automatic logic head_hit(logic [3:0] i, logic [7:0] c);
    logic h;
    case (i)
      4'd0: h = (c == "H");
      4'd1: h = (c == "E");
      4'd2: h = (c == "A");
      4'd3: h = (c == "D");
      default: h = 1'b0;
    endcase
    return h;
  endfunction

  function automatic logic ver_hit(logic [3:0] i, logic [7:0] c);
    logic h;
    case (i)
      4'd0: h = (c == "H");
      4'd1: h = (c == "T");
      4'd2: h = (c == "T");
      4'd3: h = (c == "P");
      4'd4: h = (c == "/");
      4'd5: h = (c == "1");
      4'd6: h = (c == ".");
      4'd7: h = (c == "0");
      default: h = 1'b0;
    endcase
    return h;
  endfunction

  // a space ends the current token and settles method or version
  function automatic st_t close_tok(st_t s);
    st_t n;
    n = s;
    if (s.in_tok) begin
      n.in_tok = 1'b0;
      if (!s.extra) begin
        if (s.tc == 2'd1) begin
          if (s.alive[0] && s.cit == 4'd3) n.meth = MethGet;
          else if (s.alive[1] && s.cit == 4'd4) n.meth = MethPost;
          else if (s.alive[2] && s.cit == 4'd4) n.meth = MethHead;
          else n.meth = MethNone;
        end else if (s.tc == 2'd3) begin
          n.vok = s.alive[0] && (s.cit == 4'd8);
        end
      end
    end
    return n;
  endfunction

  function automatic st_t take_chr(st_t s, logic [7:0] c);
    st_t n;
    n = s;
    if (!n.in_tok) begin
      n.in_tok = 1'b1;
      if (n.tc != 2'd3) n.tc = n.tc + 2'd1;
      else n.extra = 1'b1;
      n.cit = 4'd0;
      n.alive = 4'hF;
      if (n.tc == 2'd2 && !n.extra) begin
        n.poff = n.pos;
        n.pcnt = 10'd0;
      end
    end
    if (!n.extra) begin
      if (n.cit < CharSat) begin
        if (n.tc == 2'd1) begin
          n.alive[0] = n.alive[0] & get_hit(n.cit, c);
          n.alive[1] = n.alive[1] & post_hit(n.cit, c);
          n.alive[2] = n.alive[2] & head_hit(n.cit, c);
        end else if (n.tc == 2'd3) begin
          n.alive[0] = n.alive[0] & ver_hit(n.cit, c);
        end
        n.cit = n.cit + 4'd1;
      end
      if (n.tc == 2'd2 && n.pcnt != CntMax) n.pcnt = n.pcnt + 10'd1;
    end
    return n;
  endfunction

endpackage

/* hdl/hrlc_line_if.sv */
interface hrlc_line_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       line_end;

  modport source (output valid, output line_byte, output line_end, input ready);
  modport sink (input valid, input line_byte, input line_end, output ready);
endinterface

/* hdl/hrlc_result_if.sv */
interface hrlc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] method;
  logic       bad_request;
  logic       bad_version;
  logic       short_path;
  logic       no_tokens;
  logic [9:0] path_start;
  logic [9:0] path_length;

  modport source (
    output valid, output method, output bad_request, output bad_version,
    output short_path, output no_tokens, output path_start, output path_length,
    input ready
  );
  modport sink (
    input valid, input method, input bad_request, input bad_version,
    input short_path, input no_tokens, input path_start, input path_length,
    output ready
  );
endinterface

/* hdl/http_request_line_classifier.sv */
// Request line classifier.
// line_i takes the line one byte per transaction; line_end marks its last byte.
// result_o gives one transaction per line, after the last byte: method code,
// error flags and the path's start offset and length.
// Bytes are captured in an input register, then the tokenizer state is
// updated from that register in one step while the result register loads.
// The last byte passes the input register, then the result register, before result valid.
// Throughput: one byte per cycle while no finished line waits on a stalled receiver;
// the tokenizer state update of one byte is the only loop.
// A line may start in the cycle after the previous one ended; the byte
// register keeps filling while a finished result waits on the receiver.
// When the receiver stalls, only a last byte is held in the input register,
// and line_i.ready drops until the pending result is taken.
// Reset clears the tokenizer and both valid flags; no result is pending.
// Byte offsets saturate at MaxLine - 1 (1023), path length at 1023.
module http_request_line_classifier (
  input logic         clk_i,
  input logic         rst_ni,
  hrlc_line_if.sink   line_i,
  hrlc_result_if.source result_o
);
  import hrlc_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_adv;
  logic       out_valid_q;
  res_t       res_q;
  res_t       res_d;
  st_t        st_q;
  st_t        st_d;

  // the input register moves on unless a finished line meets a full output
  assign s1_adv = s1_valid_q && (!s1_last_q || !out_valid_q || result_o.ready);
  assign line_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    st_t s;
    res_t r;
    s = st_q;
    r = '{method: MethNone, path_start: 10'd0, path_length: 10'd0, default: 1'b0};
    if (s1_byte_q == Space) s = close_tok(s);
    else s = take_chr(s, s1_byte_q);
    if (s.pos < PosMax) s.pos = s.pos + 10'd1;
    if (s1_last_q) begin
      s = close_tok(s);
      if (s.tc == 2'd0) begin
        r.no_tokens = 1'b1;
      end else begin
        r.method = s.meth;
        if (s.meth == MethNone) r.bad_request = 1'b1;
        if (s.tc < 2'd2) begin
          r.bad_request = 1'b1;
        end else begin
          r.path_start = s.poff;
          r.path_length = s.pcnt;
          if (s.pcnt <= 10'd1) r.short_path = 1'b1;
          if (s.tc < 2'd3) r.bad_request = 1'b1;
          else if (!s.vok) r.bad_version = 1'b1;
        end
      end
      s = StReset;
    end
    st_d = s;
    res_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      st_q <= StReset;
    end else begin
      if (line_i.ready) s1_valid_q <= line_i.valid;
      if (s1_adv) st_q <= st_d;
      if (s1_adv && s1_last_q) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_i.ready && line_i.valid) begin
      s1_byte_q <= line_i.line_byte;
      s1_last_q <= line_i.line_end;
    end
    if (s1_adv && s1_last_q) res_q <= res_d;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.method = res_q.method;
  assign result_o.bad_request = res_q.bad_request;
  assign result_o.bad_version = res_q.bad_version;
  assign result_o.short_path = res_q.short_path;
  assign result_o.no_tokens = res_q.no_tokens;
  assign result_o.path_start = res_q.path_start;
  assign result_o.path_length = res_q.path_length;

`ifndef ASSERT_OFF
  a_no_tokens_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.no_tokens) |-> (res_q.method == MethNone &&
      !res_q.bad_request && !res_q.bad_version && !res_q.short_path &&
      res_q.path_start == 10'd0 && res_q.path_length == 10'd0))
    else $error("no_tokens result carries other fields");

  a_missing_path_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.no_tokens && res_q.path_length == 10'd0) |->
      res_q.bad_request)
    else $error("missing path not flagged invalid");

  a_short_path_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.short_path == (res_q.path_length == 10'd1)))
    else $error("short_path disagrees with path length");

  a_clear_after_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (st_q.tc == 2'd0 && !st_q.in_tok &&
      st_q.pos == 10'd0 && !st_q.extra))
    else $error("tokenizer state not cleared after line end");
`endif

endmodule

/* bench/tb_http_request_line_classifier.sv */
module tb_http_request_line_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import hrlc_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } line_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hrlc_line_if   line_bus ();
  hrlc_result_if result_bus ();

  http_request_line_classifier i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .line_i   (line_bus),
    .result_o (result_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  line_beat_t pending_beats[$];
  res_t       expected_verdicts[$];
  logic [7:0] line_buf[$];

  // tokenizer mirror
  logic [9:0] col;
  logic [1:0] tok_idx;
  logic       in_word;
  logic [3:0] word_len;
  logic [7:0] word_buf [0:8];
  method_e    meth_seen;
  logic [9:0] path_at;
  logic [9:0] path_chars;
  logic       version_good;
  logic       past_third;

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned lines_checked = 0;
  int unsigned meth_hits [0:3] = '{0, 0, 0, 0};
  int unsigned bad_lines = 0;
  int unsigned unsup_lines = 0;
  int unsigned empty_lines = 0;
  int unsigned blank_lines = 0;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_left = 0;
  int   holds_asked = 0;
  int   holds_served = 0;
  logic line_taken = 1'b0;

  string near_miss [0:9] = '{"GE", "GETS", "POS", "POSTT", "HEA", "HEADS", "GOT", "PUT",
                             "get", "HEAP"};

  task automatic clear_parser();
    col = '0;
    tok_idx = '0;
    in_word = 1'b0;
    word_len = '0;
    meth_seen = MethNone;
    path_at = '0;
    path_chars = '0;
    version_good = 1'b0;
    past_third = 1'b0;
  endtask

  // exact match of the current token against a keyword
  function automatic logic word_is(string w);
    logic hit;
    hit = (word_len == w.len());
    for (int k = 0; k < w.len(); k++) begin
      if (hit && word_buf[k] != w[k]) hit = 1'b0;
    end
    return hit;
  endfunction

  task automatic finish_word();
    if (in_word) begin
      in_word = 1'b0;
      if (!past_third) begin
        if (tok_idx == 2'd1) begin
          if (word_is("GET")) meth_seen = MethGet;
          else if (word_is("POST")) meth_seen = MethPost;
          else if (word_is("HEAD")) meth_seen = MethHead;
          else meth_seen = MethNone;
        end else if (tok_idx == 2'd3) begin
          version_good = word_is("HTTP/1.0");
        end
      end
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    res_t v;
    if (b == Space) begin
      finish_word();
    end else begin
      if (!in_word) begin
        in_word = 1'b1;
        if (tok_idx != 2'd3) tok_idx = tok_idx + 2'd1;
        else past_third = 1'b1;
        word_len = '0;
        if (tok_idx == 2'd2 && !past_third) begin
          path_at = col;
          path_chars = '0;
        end
      end
      if (!past_third) begin
        // only the first nine characters matter for keyword matching
        if (word_len < 4'd9) begin
          word_buf[word_len] = b;
          word_len = word_len + 4'd1;
        end
        if (tok_idx == 2'd2 && path_chars != CntMax) path_chars = path_chars + 10'd1;
      end
    end
    if (col < PosMax) col = col + 10'd1;
    if (last) begin
      finish_word();
      v = '0;
      if (tok_idx == 2'd0) begin
        v.no_tokens = 1'b1;
      end else begin
        v.method = meth_seen;
        v.bad_request = (meth_seen == MethNone);
        if (tok_idx < 2'd2) begin
          v.bad_request = 1'b1;
        end else begin
          v.path_start = path_at;
          v.path_length = path_chars;
          v.short_path = (path_chars <= 10'd1);
          if (tok_idx < 2'd3) v.bad_request = 1'b1;
          else if (!version_good) v.bad_version = 1'b1;
        end
      end
      expected_verdicts.push_back(v);
      meth_hits[v.method]++;
      bad_lines += v.bad_request;
      unsup_lines += v.bad_version;
      empty_lines += v.short_path;
      blank_lines += v.no_tokens;
      clear_parser();
    end
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned seen);
    if (want != seen) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
    end
  endtask

  task automatic check_verdict();
    res_t want;
    if (expected_verdicts.size() == 0) begin
      mismatches++;
      $display("%0t: result transaction with nothing expected, got method %0d start %0d len %0d",
               $time, result_bus.method, result_bus.path_start, result_bus.path_length);
    end else begin
      want = expected_verdicts.pop_front();
      lines_checked++;
      check_field("method", want.method, result_bus.method);
      check_field("bad_request", want.bad_request, result_bus.bad_request);
      check_field("bad_version", want.bad_version, result_bus.bad_version);
      check_field("short_path", want.short_path, result_bus.short_path);
      check_field("no_tokens", want.no_tokens, result_bus.no_tokens);
      check_field("path_start", want.path_start, result_bus.path_start);
      check_field("path_length", want.path_length, result_bus.path_length);
    end
  endtask

  // monitor: checks results and feeds accepted bytes to the predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        if (result_bus.valid && result_bus.ready) check_verdict();
        if (line_bus.valid && line_bus.ready) begin
          absorb_byte(line_bus.line_byte, line_bus.line_end);
          bytes_sent++;
        end
      end
    end
    line_taken <= rst_ni && line_bus.valid && line_bus.ready;
  end

  // driver
  always @(negedge clk_i) begin
    line_beat_t beat;
    if (rst_ni && (!line_bus.valid || line_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        line_bus.valid <= 1'b0;
      end else if ($urandom_range(0, 99) < send_idle_pct) begin
        send_gap = $urandom_range(0, 14);
        line_bus.valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        beat = pending_beats.pop_front();
        line_bus.valid <= 1'b1;
        line_bus.line_byte <= beat.chr;
        line_bus.line_end <= beat.last;
      end else begin
        line_bus.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(0, 14);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] rand_word_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == Space) c = 8'h21;
    return c;
  endfunction

  task automatic add_text(string s);
    for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
  endtask

  task automatic add_spaces(int n);
    repeat (n) line_buf.push_back(Space);
  endtask

  task automatic add_word_chars(int n);
    repeat (n) line_buf.push_back(rand_word_char());
  endtask

  task automatic add_gap();
    add_spaces(($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1);
  endtask

  task automatic commit_line();
    if (line_buf.size() == 0) line_buf.push_back(Space);
    foreach (line_buf[k]) begin
      pending_beats.push_back('{chr: line_buf[k], last: k == line_buf.size() - 1});
    end
    line_buf.delete();
  endtask

  task automatic make_request_line();
    string ver;
    int    shape;
    if ($urandom_range(0, 3) == 0) add_spaces($urandom_range(1, 3));
    case ($urandom_range(0, 9))
      0, 1, 2: add_text("GET");
      3, 4:    add_text("POST");
      5, 6:    add_text("HEAD");
      7:       add_text(near_miss[$urandom_range(0, 9)]);
      default: add_word_chars($urandom_range(1, 10));
    endcase
    shape = $urandom_range(0, 9);
    if (shape != 0) begin
      add_gap();
      if ($urandom_range(0, 7) != 0) add_text("/");
      add_word_chars(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12));
      if (shape != 1) begin
        add_gap();
        ver = "HTTP/1.0";
        case ($urandom_range(0, 7))
          4: ver = "HTTP/1.1";
          5: ver[$urandom_range(0, 7)] = rand_word_char();
          6: ver = ver.substr(0, $urandom_range(0, 6));
          default: ;
        endcase
        add_text(ver);
        if ($urandom_range(0, 7) == 0) add_word_chars($urandom_range(1, 2));
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            add_gap();
            add_word_chars($urandom_range(1, 6));
          end
        end
      end
    end
    if ($urandom_range(0, 4) == 0) add_spaces($urandom_range(1, 3));
    commit_line();
  endtask

  task automatic make_random_line();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      add_spaces($urandom_range(1, 5));
      commit_line();
    end else if (pick <= 3) begin
      // garbage with a fair share of separators
      repeat ($urandom_range(1, 24)) begin
        if ($urandom_range(0, 3) == 0) line_buf.push_back(Space);
        else line_buf.push_back(8'($urandom_range(0, 255)));
      end
      commit_line();
    end else begin
      make_request_line();
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_beats.size() != 0 || line_bus.valid || expected_verdicts.size() != 0);
  endtask

  initial begin
    line_bus.valid = 1'b0;
    line_bus.line_byte = '0;
    line_bus.line_end = 1'b0;
    result_bus.ready = 1'b0;
    clear_parser();
    repeat (11) @(posedge clk_i);
    rst_ni = 1'b1;

    // directed lines
    send_idle_pct = 20;
    recv_idle_pct = 20;
    add_spaces(1);
    commit_line();
    add_spaces(3);
    commit_line();
    add_text("GET / HTTP/1.0");
    commit_line();
    add_text("POST /form HTTP/1.0");
    commit_line();
    add_text("HEAD /x HTTP/1.1");
    commit_line();
    add_text("GETX /a HTTP/1.0");
    commit_line();
    add_text("GET");
    commit_line();
    add_text("HEAD /idx");
    commit_line();
    add_text("  POST   /a   HTTP/1.0   extra tok  ");
    commit_line();
    add_text("GET /");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    add_text(" HTTP/1.0");
    commit_line();
    add_text("G");
    commit_line();
    add_text("GET  HTTP/1.0X");
    commit_line();
    add_text("HEAD /p HTTP/1.00");
    commit_line();
    // sender waits here until every result is back
    drain();

    // random lines, with the receiver held off while bytes keep coming
    send_idle_pct = 10;
    recv_idle_pct = 30;
    repeat (10) make_random_line();
    holds_asked++;
    add_text("GET /");
    add_word_chars($urandom_range(1024, 1040));
    add_text(" HTTP/1.0");
    commit_line();
    repeat (6) make_random_line();
    drain();

    send_idle_pct = 35;
    recv_idle_pct = 5;
    repeat (4) make_random_line();
    drain();

    // no idling on either side at the end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_gap = 0;
    recv_gap = 0;
    repeat (5) make_random_line();
    drain();
    repeat (10) @(posedge clk_i);

    if (expected_verdicts.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, expected_verdicts.size());
    end
    $display("%0d bytes, %0d lines: GET %0d POST %0d HEAD %0d unknown %0d, blank %0d",
             bytes_sent, lines_checked, meth_hits[1], meth_hits[2], meth_hits[3],
             meth_hits[0], blank_lines);
    $display("flags seen: invalid %0d, unsupported version %0d, short path %0d",
             bad_lines, unsup_lines, empty_lines);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
